// File: rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// shared opcodes and the control/status bundles between controller and datapath
// ----------------------------------------------------------------------------
package pip_pkg;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_CLEAR  = 2'd0;
   localparam opcode_type OP_APPEND = 2'd1;
   localparam opcode_type OP_QUERY  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic accept;    // request word taken this cycle
      logic read_en;   // issue one vertex read of the edge walk
      logic out_load;  // move finished result into the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;  // polygon holds no vertex
      logic last_read;   // current read is the last of the walk
      logic pipe_busy;   // edge pipeline still holds work
   } sts_type;

endpackage

// File: rtl/pip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ctrl
// sequencer: takes a request word, runs the edge walk, hands off the result
// ----------------------------------------------------------------------------
module pip_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pip_pkg::opcode_type req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pip_pkg::cmd_type    cmd,
   input  pip_pkg::sts_type    sts
);
   import pip_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_opcode == OP_QUERY && !sts.count_zero) state_in = S_READ;
               else state_in = S_DONE;
            end
         end
         S_READ: begin
            cmd.read_en = 1'b1;
            if (sts.last_read) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/pip_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_datapath
// vertex memory, count, edge pipeline with exact cross-multiplied test
// ----------------------------------------------------------------------------
module pip_datapath #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16,
   parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pip_pkg::opcode_type          req_opcode,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                         rsp_inside_res,
   output logic                         rsp_status,
   output logic [CNT_W-1:0]             rsp_vertices_held,
   input  pip_pkg::cmd_type             cmd,
   output pip_pkg::sts_type             sts
);
   import pip_pkg::*;

   localparam int W  = COORD_BITS;
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DW = W + 1;
   localparam int PW = 2 * DW;

   // vertex store, x in the upper half
   logic [2*W-1:0] mem [MAX_VERTICES];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_cnt_ff;
   logic [AW-1:0]    rd_addr;
   logic             full;
   logic             do_append;

   logic signed [W-1:0] qx_ff, qy_ff;
   logic                inside_ff, status_ff;

   // stage 1: registered memory word
   logic           v1_ff, first1_ff;
   logic [2*W-1:0] rd_data_ff;
   // previous vertex of the walk
   logic signed [W-1:0] prev_x_ff, prev_y_ff;
   logic signed [W-1:0] cur_x, cur_y;
   // stage 2: differences
   logic                 v2_ff, span2_ff, dyneg2_ff;
   logic signed [DW-1:0] a_ff, dy_ff, c_ff, d_ff;
   logic                 span;
   // stage 3: products
   logic                 v3_ff, span3_ff, dyneg3_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic                 left;

   assign full      = (count_ff == CNT_W'(MAX_VERTICES));
   assign do_append = cmd.accept && (req_opcode == OP_APPEND) && !full;

   always_comb begin
      count_in = count_ff;
      if (cmd.accept && req_opcode == OP_CLEAR) count_in = '0;
      else if (do_append) count_in = count_ff + CNT_W'(1);
   end

   // walk order: last vertex first, then 0 .. n-1
   always_comb begin
      if (rd_cnt_ff == '0) rd_addr = AW'(count_ff - CNT_W'(1));
      else rd_addr = AW'(rd_cnt_ff - CNT_W'(1));
   end

   assign sts.count_zero = (count_ff == '0);
   assign sts.last_read  = (rd_cnt_ff == count_ff);
   assign sts.pipe_busy  = v1_ff || v2_ff || v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         v1_ff    <= cmd.read_en;
         v2_ff    <= v1_ff && !first1_ff;
         v3_ff    <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_append) mem[count_ff[AW-1:0]] <= {req_coord_x, req_coord_y};
      if (cmd.read_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_cnt_ff <= '0;
         qx_ff     <= req_coord_x;
         qy_ff     <= req_coord_y;
         status_ff <= (req_opcode == OP_APPEND) && full;
      end else if (cmd.read_en) begin
         rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
      end
      first1_ff <= (rd_cnt_ff == '0);
   end

   // stage 2: edge from prev (j) to cur (i)
   assign cur_x = rd_data_ff[2*W-1:W];
   assign cur_y = rd_data_ff[W-1:0];
   assign span  = ((cur_y <= qy_ff) && (qy_ff < prev_y_ff)) ||
                  ((prev_y_ff <= qy_ff) && (qy_ff < cur_y));

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
      a_ff      <= DW'(qx_ff) - DW'(cur_x);
      dy_ff     <= DW'(prev_y_ff) - DW'(cur_y);
      c_ff      <= DW'(prev_x_ff) - DW'(cur_x);
      d_ff      <= DW'(qy_ff) - DW'(cur_y);
      span2_ff  <= span;
      dyneg2_ff <= (prev_y_ff < cur_y);
   end

   // stage 3: both products at full width
   always_ff @(posedge clock) begin
      p1_ff     <= PW'(a_ff) * PW'(dy_ff);
      p2_ff     <= PW'(c_ff) * PW'(d_ff);
      span3_ff  <= span2_ff;
      dyneg3_ff <= dyneg2_ff;
   end

   // stage 4: compare, direction follows the sign of dy
   assign left = dyneg3_ff ? (p1_ff > p2_ff) : (p1_ff < p2_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) inside_ff <= 1'b0;
      else if (v3_ff && span3_ff && left) inside_ff <= !inside_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_inside_res    <= inside_ff;
         rsp_status        <= status_ff;
         rsp_vertices_held <= count_ff;
      end
   end

endmodule

// File: rtl/point_in_polygon_test.sv
`timescale 1ns / 1ps
// clear, append, unused opcode and a query on an empty polygon go straight to the result hand-off
// a query on a non-empty polygon reads every vertex, drains the edge pipeline, then gives its word
// the next word is taken only when the result of the last one is out
// the query time is set by the single vertex memory read port, one edge per cycle
// reset: synchronous, clears the vertex count, sequencer state, pipeline valids and response valid; store stays as is
// ----------------------------------------------------------------------------
// point_in_polygon_test
// even-odd crossing test of a point against a stored polygon
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request word
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  pip_pkg::opcode_type                     req_opcode,
   input  logic signed [COORD_BITS-1:0]            req_coord_x,
   input  logic signed [COORD_BITS-1:0]            req_coord_y,
   // response word
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_inside_res,
   output logic                                    rsp_status,
   output logic [$clog2(MAX_VERTICES+1)-1:0]       rsp_vertices_held
);
   import pip_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: idle, vertex walk, pipeline drain, result hand-off
   pip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath: vertex memory, count, four-stage edge pipeline,
   // response register that holds while the consumer stalls
   pip_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .CNT_W        (CNT_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_status        (rsp_status),
      .rsp_vertices_held (rsp_vertices_held),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

// File: rtl/pip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_checker
// port-level checks of the point-in-polygon block, bound to the top level
// ----------------------------------------------------------------------------
module pip_checker #(
   parameter int MAX_VERTICES = 64,
   parameter int CNT_W        = 7
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_inside_res,
   input logic             rsp_status,
   input logic [CNT_W-1:0] rsp_vertices_held
);

   // a stalled response word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   // a dropped vertex only happens with a full store
   a_status_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_vertices_held == CNT_W'(MAX_VERTICES))
      else $error("drop flagged with store not full");

   // fewer than three vertices never enclose a point
   a_inside_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> rsp_vertices_held >= CNT_W'(3))
      else $error("inside reported for a degenerate polygon");

   // one word at a time: the block is busy right after taking a word
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous word in flight");

endmodule

bind point_in_polygon_test pip_checker #(
   .MAX_VERTICES (MAX_VERTICES),
   .CNT_W        ($clog2(MAX_VERTICES + 1))
) u_pip_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_inside_res    (rsp_inside_res),
   .rsp_status        (rsp_status),
   .rsp_vertices_held (rsp_vertices_held)
);

// File: test/point_in_polygon_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb
// drives clear, append, query and unused-opcode words into the polygon block
// and checks every response word against a typed-in answer or a local
// even-odd crossing predictor; requests idle and responses stall at random
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;

   import pip_pkg::*;

   localparam int MAX_VERTS    = 64;
   localparam int CLOCK_PERIOD = 20;
   localparam int ITEM_TARGET  = 1200;
   localparam int IDLE_LIMIT   = 4000;   // cycles with no word moving on either side
   localparam int DRAIN_CYCLES = 100;

   // opcode 3 has no meaning in the block, it only echoes the count
   localparam opcode_type OP_NOP = 2'd3;

   localparam logic signed [15:0] COORD_MIN = 16'sh8000;
   localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;

   // one response word as the block should give it
   typedef struct packed {
      logic       in_poly;
      logic       status;
      logic [6:0] held;
   } answer_type;

   // one row of the directed part; answers typed in only where obvious
   typedef struct {
      opcode_type         op;
      logic signed [15:0] x;
      logic signed [15:0] y;
      bit                 typed;
      answer_type         answer;
   } stim_row_type;

   // how the response side holds off the block
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   opcode_type          req_opcode;
   logic signed [15:0]  req_coord_x;
   logic signed [15:0]  req_coord_y;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_inside_res;
   logic                rsp_status;
   logic [6:0]          rsp_vertices_held;

   // predictor state: the polygon as the block should hold it
   logic signed [15:0]  poly_x [0:MAX_VERTS-1];
   logic signed [15:0]  poly_y [0:MAX_VERTS-1];
   int                  poly_count;

   answer_type          answer_queue [$];
   int                  mismatches;
   int                  items_sent;
   int                  burst_left;
   int                  idle_cycles;
   stall_style_type     stall_style;
   int                  style_left;
   int                  stall_phase;

   point_in_polygon_test #(
      .MAX_VERTICES (MAX_VERTS),
      .COORD_BITS   (16)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_status        (rsp_status),
      .rsp_vertices_held (rsp_vertices_held)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // directed words: empty polygon, single vertex, corner extremes,
   // unused opcode, clear with stale entries left behind, a small square
   stim_row_type directed_rows [0:23] = '{
      '{OP_QUERY,  16'sd0,    16'sd0,    1'b1, '{1'b0, 1'b0, 7'd0}},  // empty -> outside
      '{OP_NOP,    COORD_MAX, COORD_MIN, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_APPEND, COORD_MIN, COORD_MIN, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{OP_QUERY,  COORD_MIN, COORD_MIN, 1'b1, '{1'b0, 1'b0, 7'd1}},  // one vertex, no y span
      '{OP_QUERY,  16'sd0,    16'sd0,    1'b1, '{1'b0, 1'b0, 7'd1}},
      '{OP_APPEND, COORD_MAX, COORD_MIN, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{OP_APPEND, 16'sd0,    COORD_MAX, 1'b1, '{1'b0, 1'b0, 7'd3}},
      '{OP_QUERY,  16'sd0,    16'sd0,    1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_QUERY,  COORD_MAX, COORD_MAX, 1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_QUERY,  COORD_MIN, 16'sd0,    1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_QUERY,  16'sd0,    COORD_MIN, 1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_QUERY,  -16'sd1,   16'sh7FFE, 1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_NOP,    -16'sd1,   -16'sd1,   1'b1, '{1'b0, 1'b0, 7'd3}},
      '{OP_CLEAR,  -16'sd1,   -16'sd1,   1'b1, '{1'b0, 1'b0, 7'd0}},
      '{OP_QUERY,  16'sd0,    16'sd0,    1'b1, '{1'b0, 1'b0, 7'd0}},  // stale entries unused
      '{OP_APPEND, -16'sd256, -16'sd256, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{OP_APPEND, 16'sd256,  -16'sd256, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{OP_APPEND, 16'sd256,  16'sd256,  1'b1, '{1'b0, 1'b0, 7'd3}},
      '{OP_APPEND, -16'sd256, 16'sd256,  1'b1, '{1'b0, 1'b0, 7'd4}},
      '{OP_QUERY,  16'sd0,    16'sd0,    1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_QUERY,  16'sd256,  16'sd0,    1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_QUERY,  -16'sd256, -16'sd256, 1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_QUERY,  16'sd0,    16'sd256,  1'b0, '{1'b0, 1'b0, 7'd0}},
      '{OP_CLEAR,  16'sd0,    16'sd0,    1'b1, '{1'b0, 1'b0, 7'd0}}
   };

   // even-odd parity of the edges that the ray to the right of (px,py) crosses
   function automatic logic ray_parity(input logic signed [15:0] px,
                                       input logic signed [15:0] py);
      longint xi, yi, xj, yj, dy, lhs, rhs;
      int     j;
      logic   parity;
      bit     left;
      parity = 1'b0;
      for (int i = 0; i < poly_count; i++) begin
         j  = (i == 0) ? poly_count - 1 : i - 1;
         xi = poly_x[i];
         yi = poly_y[i];
         xj = poly_x[j];
         yj = poly_y[j];
         // half-open y span, so a horizontal edge never counts
         if (((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi))) begin
            dy  = yj - yi;
            // cross-multiplied form of the intersection x, exact at 64 bits
            lhs = (px - xi) * dy;
            rhs = (xj - xi) * (py - yi);
            left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
            if (left) parity = ~parity;
         end
      end
      return parity;
   endfunction

   // applies one word to the predicted polygon and returns the expected answer
   function automatic answer_type polygon_apply(input opcode_type op,
                                                input logic signed [15:0] px,
                                                input logic signed [15:0] py);
      answer_type a;
      a = '0;
      case (op)
         OP_CLEAR: begin
            poly_count = 0;
         end
         OP_APPEND: begin
            if (poly_count < MAX_VERTS) begin
               poly_x[poly_count] = px;
               poly_y[poly_count] = py;
               poly_count++;
            end else begin
               a.status = 1'b1;   // store full, vertex dropped
            end
         end
         OP_QUERY: begin
            a.in_poly = ray_parity(px, py);
         end
         default: ;
      endcase
      a.held = 7'(poly_count);
      return a;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // presents one request word, holds it until taken, then queues its answer;
   // the sender runs in bursts with random gaps in between
   task automatic send_word(input opcode_type op,
                            input logic signed [15:0] px,
                            input logic signed [15:0] py,
                            input bit use_typed,
                            input answer_type typed_answer);
      int         gap;
      answer_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_coord_x <= px;
      req_coord_y <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // word taken at this edge
      predicted = polygon_apply(op, px, py);
      answer_queue.push_back(use_typed ? typed_answer : predicted);
      burst_left--;
      if (op != OP_NOP) items_sent++;
   endtask

   // coordinate at one of three spreads: full range, moderate, tight
   // (the tight one gives shared y values, horizontal edges and hits on vertices)
   function automatic logic signed [15:0] random_coord(input int spread);
      case (spread)
         0:       return 16'($urandom);
         1:       return 16'(int'($urandom_range(0, 2048)) - 1024);
         default: return 16'(int'($urandom_range(0, 32)) - 16);
      endcase
   endfunction

   // random words: mostly a clear, a polygon of random size, then queries,
   // with noise words mixed in; some polygons overrun the store
   task automatic random_phases();
      int                 n_verts;
      int                 n_queries;
      int                 spread;
      int                 pick;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      while (items_sent < ITEM_TARGET) begin
         spread  = $urandom_range(0, 2);
         n_verts = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(3, 12);
         // now and then keep the old polygon and append onto it
         if ($urandom_range(0, 7) != 0)
            send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0, '0);
         for (int v = 0; v < n_verts; v++) begin
            if ($urandom_range(0, 11) == 0)
               send_word(opcode_type'($urandom_range(0, 3)), 16'($urandom),
                         16'($urandom), 1'b0, '0);
            send_word(OP_APPEND, random_coord(spread), random_coord(spread),
                      1'b0, '0);
         end
         n_queries = $urandom_range(3, 10);
         for (int q = 0; q < n_queries; q++) begin
            qx = random_coord(spread);
            qy = random_coord(spread);
            // aim at a stored vertex, or at its height only
            if (poly_count > 0 && $urandom_range(0, 3) == 0) begin
               pick = $urandom_range(0, poly_count - 1);
               qy   = poly_y[pick];
               if ($urandom_range(0, 1) == 0) qx = poly_x[pick];
            end
            if ($urandom_range(0, 11) == 0)
               send_word(opcode_type'($urandom_range(0, 3)), 16'($urandom),
                         16'($urandom), 1'b0, '0);
            send_word(OP_QUERY, qx, qy, 1'b0, '0);
         end
      end
   endtask

   // response side: stall style changes now and then at random,
   // including long stretches with no stall at all
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_style <= STALL_NONE;
         style_left  <= 0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (style_left == 0) begin
            stall_style <= stall_style_type'($urandom_range(0, 3));
            style_left  <= $urandom_range(50, 300);
         end else begin
            style_left <= style_left - 1;
         end
         case (stall_style)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_stall <= (stall_phase % 3 == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // response check: each taken word against the oldest expected answer
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_queue.size() == 0) begin
            report_mismatch("response word with no answer pending");
         end else begin
            want = answer_queue.pop_front();
            if (rsp_inside_res !== want.in_poly)
               report_mismatch($sformatf("inside_res got %b want %b",
                                         rsp_inside_res, want.in_poly));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %b want %b",
                                         rsp_status, want.status));
            if (rsp_vertices_held !== want.held)
               report_mismatch($sformatf("vertices_held got %0d want %0d",
                                         rsp_vertices_held, want.held));
         end
      end
   end

   // watchdog: ends the run when no word moves on either side for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("point_in_polygon_test verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = OP_CLEAR;
      req_coord_x = '0;
      req_coord_y = '0;
      mismatches  = 0;
      items_sent  = 0;
      burst_left  = 0;
      idle_cycles = 0;
      poly_count  = 0;
      for (int i = 0; i < MAX_VERTS; i++) begin
         poly_x[i] = '0;
         poly_y[i] = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_word(directed_rows[r].op, directed_rows[r].x, directed_rows[r].y,
                   directed_rows[r].typed, directed_rows[r].answer);

      random_phases();
      req_valid <= 1'b0;

      // drain, then leave room for any stray word
      while (answer_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("point_in_polygon_test verification clean");
      end else begin
         $display("point_in_polygon_test verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/pip_pkg.sv
rtl/pip_ctrl.sv
rtl/pip_datapath.sv
rtl/point_in_polygon_test.sv
rtl/pip_checker.sv
test/point_in_polygon_test_tb.sv
